// ===== src/tks_pkg.sv =====
// ----------------------------------------------------------------------------
// Top-k score keeper package
// Shared widths and the insert command passed from the sequencer to the store.
// ----------------------------------------------------------------------------
package tks_pkg;

   // Field widths
   localparam int unsigned ID_W    = 16;
   localparam int unsigned SCORE_W = 16;
   localparam int unsigned RANK_W  = 3;
   localparam int unsigned LIMIT_W = 3;

   // Slot positions in the insert command; covers the deepest supported ranking
   localparam int unsigned SLOT_W = 6;

   // Reset value of the limit register
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd5;

   // Insert command: write the new entry at pos, move pos..tail-1 down by one
   typedef struct packed {
      logic               wr;
      logic [SLOT_W-1:0]  pos;
      logic [SLOT_W-1:0]  tail;
      logic [SCORE_W-1:0] score;
      logic [ID_W-1:0]    id;
   } tks_ins_type;

endpackage

// ===== src/tks_store.sv =====
// ----------------------------------------------------------------------------
// Top-k score keeper entry store
// Ranked (id, score) slots with one read port and a registered shift insert.
// ----------------------------------------------------------------------------
module tks_store
   import tks_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = 5,
   parameter int unsigned IDX_W       = 3
) (
   input  logic               clock,
   input  tks_ins_type        ins,
   input  logic [IDX_W-1:0]   rd_idx,
   output logic [SCORE_W-1:0] rd_score,
   output logic [ID_W-1:0]    rd_id
);

   logic [SCORE_W-1:0] scores_ff [0:MAX_ENTRIES-1];
   logic [ID_W-1:0]    ids_ff    [0:MAX_ENTRIES-1];

   // Update each slot: take the new entry, or the one above it when shifting
   for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_slot
      localparam logic [SLOT_W-1:0] SlotNum = SLOT_W'(j);
      always_ff @(posedge clock) begin
         if (ins.wr) begin
            if (SlotNum == ins.pos) begin
               scores_ff[j] <= ins.score;
               ids_ff[j]    <= ins.id;
            end else if (j > 0 && SlotNum > ins.pos && SlotNum <= ins.tail) begin
               scores_ff[j] <= scores_ff[(j > 0) ? j - 1 : 0];
               ids_ff[j]    <= ids_ff[(j > 0) ? j - 1 : 0];
            end
         end
      end
   end

   // Read the slot under the sequencer's index
   assign rd_score = scores_ff[rd_idx];
   assign rd_id    = ids_ff[rd_idx];

endmodule

// ===== src/tks_ctrl.sv =====
// ----------------------------------------------------------------------------
// Top-k score keeper sequencer
// Scans the ranking with one comparator, issues the insert, then emits beats.
// ----------------------------------------------------------------------------
module tks_ctrl
   import tks_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = 5,
   parameter int unsigned CNT_W       = 3,
   parameter int unsigned IDX_W       = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [LIMIT_W-1:0] limit,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [ID_W-1:0]    req_player_id,
   input  logic [SCORE_W-1:0] req_score,
   input  logic [SCORE_W-1:0] rd_score,
   output logic [IDX_W-1:0]   rd_idx,
   output tks_ins_type        ins,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [RANK_W-1:0]  rsp_rank,
   output logic               rsp_last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   localparam logic [CNT_W-1:0] MaxCnt  = CNT_W'(MAX_ENTRIES);
   localparam logic [CNT_W-1:0] LastPos = CNT_W'(MAX_ENTRIES - 1);

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff,   idx_in;
   logic [ID_W-1:0]    id_ff,    id_in;
   logic [SCORE_W-1:0] score_ff, score_in;

   logic [CNT_W-1:0] eff_limit;
   logic [CNT_W-1:0] new_count;
   logic [CNT_W-1:0] tail;
   logic             at_end;
   logic             hit_eq;
   logic             hit_lt;

   // Clamp the limit register to 1..MAX_ENTRIES
   always_comb begin
      if (limit == '0) begin
         eff_limit = CNT_W'(1);
      end else if (int'(limit) > int'(MAX_ENTRIES)) begin
         eff_limit = MaxCnt;
      end else begin
         eff_limit = CNT_W'(limit);
      end
   end

   // Shared comparator against the slot under the index
   assign at_end = (idx_ff == count_ff);
   assign hit_eq = !at_end && (rd_score == score_ff);
   assign hit_lt = !at_end && (rd_score < score_ff);
   assign tail   = (count_ff < MaxCnt) ? count_ff : LastPos;

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      id_in     = id_ff;
      score_in  = score_ff;
      new_count = count_ff;
      ins.wr    = 1'b0;
      ins.pos   = SLOT_W'(idx_ff);
      ins.tail  = SLOT_W'(tail);
      ins.score = score_ff;
      ins.id    = id_ff;

      case (state_ff)
         ST_IDLE: begin
            // Hold the beat and start the scan at the top
            if (req_valid) begin
               id_in    = req_player_id;
               score_in = req_score;
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit_eq) begin
               // Drop a tied score
               new_count = count_ff;
            end else if (hit_lt) begin
               // Insert in front of the lower score, shifting the rest down
               ins.wr    = 1'b1;
               new_count = tail + CNT_W'(1);
            end else if (at_end && count_ff < eff_limit) begin
               // Append below the last entry
               ins.wr    = 1'b1;
               ins.tail  = SLOT_W'(count_ff);
               new_count = count_ff + CNT_W'(1);
            end
            if (hit_eq || hit_lt || at_end) begin
               count_in = (new_count > eff_limit) ? eff_limit : new_count;
               idx_in   = '0;
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_EMIT: begin
            // Advance one rank per taken beat
            if (rsp_ready) begin
               if (rsp_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      score_ff <= score_in;
   end

   assign rd_idx    = idx_ff[IDX_W-1:0];
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_rank  = RANK_W'(idx_ff + CNT_W'(1));
   assign rsp_last  = ((idx_ff + CNT_W'(1)) == count_ff);

endmodule

// ===== src/top_k_score_keeper.sv =====
// ----------------------------------------------------------------------------
// Top-k score keeper
// Keeps a descending ranking of distinct scores and lists it after each input.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one beat carries (player_id, score). The block takes it only
//   while idle, then scans the ranking from the top with a single comparator,
//   one slot per cycle, until it finds a tie, a lower score or the end.
//   The insert (shift down plus write) happens in that final scan cycle.
//   rsp_ channel: the whole ranking follows, one beat per entry in rank order,
//   rank 1 first, rsp_last set on the final entry. The first beat is valid
//   once the scan has ended, and no new beat is taken until the listing is
//   done. req_ready rises again in the cycle after the last beat is taken.
//   A stalled receiver holds the current beat; the block waits with it.
//   csr_ channel: writes keep_limit (0 acts as 1, above MAX_ENTRIES acts as
//   MAX_ENTRIES); always ready, write only between items.
//   Reset empties the ranking and sets keep_limit to 5.
// ----------------------------------------------------------------------------
module top_k_score_keeper
   import tks_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_keep_limit,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [ID_W-1:0]    req_player_id,
   input  logic [SCORE_W-1:0] req_score,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [RANK_W-1:0]  rsp_rank,
   output logic [ID_W-1:0]    rsp_ranked_id,
   output logic [SCORE_W-1:0] rsp_ranked_score,
   output logic               rsp_last
);

   localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   logic [LIMIT_W-1:0] limit_ff;
   logic [LIMIT_W-1:0] limit_in;
   logic [IDX_W-1:0]   rd_idx;
   tks_ins_type        ins;

   // Hold the limit register
   assign csr_ready = 1'b1;
   assign limit_in  = (csr_valid) ? csr_keep_limit : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   tks_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .CNT_W       (CNT_W),
      .IDX_W       (IDX_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .limit         (limit_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_player_id (req_player_id),
      .req_score     (req_score),
      .rd_score      (rsp_ranked_score),
      .rd_idx        (rd_idx),
      .ins           (ins),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rank      (rsp_rank),
      .rsp_last      (rsp_last)
   );

   tks_store #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX_W       (IDX_W)
   ) u_store (
      .clock    (clock),
      .ins      (ins),
      .rd_idx   (rd_idx),
      .rd_score (rsp_ranked_score),
      .rd_id    (rsp_ranked_id)
   );

endmodule
